// ===== hw/rtl/skti_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package skti_pkg;

   // Request modes.
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_READ   = 1'b1;

   // Status codes returned with every result.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   // One accepted request, as handed to the engine.
   typedef struct packed {
      logic        mode;
      logic [63:0] new_key;
      logic [3:0]  read_index;
   } cmd_type;

   // One finished result, as handed back by the engine.
   typedef struct packed {
      logic [4:0]  position;
      logic [63:0] read_key;
      logic [4:0]  entry_total;
      logic [1:0]  status;
   } res_type;

   // Control from the top level to the engine.
   typedef struct packed {
      logic start;
      logic take;
   } eng_ctl_type;

   // Status from the engine to the top level.
   typedef struct packed {
      logic idle;
      logic done;
   } eng_sts_type;

endpackage

`default_nettype wire

// ===== hw/rtl/skti_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module skti_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/skti_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module skti_engine
   import skti_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_BYTES   = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire eng_ctl_type ctl,
   input  wire cmd_type     cmd,
   output eng_sts_type      sts,
   output res_type          res
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int KW = 8 * KEY_BYTES;
   localparam int IW = (CW > 4) ? CW : 4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_CHK_FIRST,
      ST_CHK_LAST,
      ST_SEARCH_RD,
      ST_SEARCH_CMP,
      ST_SHIFT_RD,
      ST_SHIFT,
      ST_STORE,
      ST_DONE
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [KW-1:0] key_ff, key_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hip1_ff, hip1_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] slot_ff, slot_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   res_type       res_ff, res_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [KW-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [KW-1:0] rd_data;
   logic [CW:0]   mid_sum;

   skti_ram #(
      .WIDTH(KW),
      .DEPTH(TABLE_DEPTH)
   ) u_key_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Midpoint of the live search range [lo, hip1 - 1].
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hip1_ff} - (CW + 1)'(1);

   // Next-state logic and memory port control. In the shift, reads and writes to the
   // same entry never share a cycle: the shift reads below the slot it writes.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      key_in   = key_ff;
      lo_in    = lo_ff;
      hip1_in  = hip1_ff;
      mid_in   = mid_ff;
      slot_in  = slot_ff;
      ptr_in   = ptr_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      wr_addr  = AW'(slot_ff);
      wr_data  = key_ff;
      rd_addr  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               key_in              = cmd.new_key[KW-1:0];
               res_in.position     = '0;
               res_in.read_key     = '0;
               res_in.entry_total  = 5'(count_ff);
               res_in.status       = STATUS_OK;
               if (cmd.mode == MODE_READ) begin
                  rd_addr = AW'(cmd.read_index);
                  if (IW'(cmd.read_index) >= IW'(count_ff)) begin
                     res_in.status = STATUS_RANGE;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_READ_WAIT;
                  end
               end else if (count_ff == CW'(TABLE_DEPTH)) begin
                  res_in.status = STATUS_FULL;
                  state_in      = ST_DONE;
               end else if (count_ff == '0) begin
                  slot_in  = '0;
                  state_in = ST_STORE;
               end else begin
                  // Entry 0 is being read for the low-end check.
                  state_in = ST_CHK_FIRST;
               end
            end
         end

         ST_READ_WAIT: begin
            res_in.read_key = 64'(rd_data);
            state_in        = ST_DONE;
         end

         ST_CHK_FIRST: begin
            if (key_ff < rd_data) begin
               slot_in  = '0;
               ptr_in   = count_ff;
               state_in = ST_SHIFT_RD;
            end else begin
               rd_addr  = AW'(count_ff - CW'(1));
               state_in = ST_CHK_LAST;
            end
         end

         ST_CHK_LAST: begin
            if (key_ff > rd_data) begin
               slot_in  = count_ff;
               state_in = ST_STORE;
            end else begin
               lo_in    = '0;
               hip1_in  = count_ff;
               state_in = ST_SEARCH_RD;
            end
         end

         ST_SEARCH_RD: begin
            if (lo_ff < hip1_ff) begin
               mid_in   = mid_sum[CW:1];
               rd_addr  = AW'(mid_sum[CW:1]);
               state_in = ST_SEARCH_CMP;
            end else begin
               slot_in  = lo_ff;
               ptr_in   = count_ff;
               state_in = (lo_ff == count_ff) ? ST_STORE : ST_SHIFT_RD;
            end
         end

         ST_SEARCH_CMP: begin
            if (key_ff < rd_data) begin
               hip1_in  = mid_ff;
               state_in = ST_SEARCH_RD;
            end else if (key_ff > rd_data) begin
               lo_in    = mid_ff + CW'(1);
               state_in = ST_SEARCH_RD;
            end else begin
               // Equal key: it takes the slot of the matching entry.
               slot_in  = mid_ff;
               ptr_in   = count_ff;
               state_in = ST_SHIFT_RD;
            end
         end

         ST_SHIFT_RD: begin
            rd_addr  = AW'(ptr_ff - CW'(1));
            state_in = ST_SHIFT;
         end

         ST_SHIFT: begin
            // Move entry ptr-1 up to ptr while the next lower one is read.
            wr_en   = 1'b1;
            wr_addr = AW'(ptr_ff);
            wr_data = rd_data;
            if ((ptr_ff - CW'(1)) > slot_ff) begin
               rd_addr = AW'(ptr_ff - CW'(2));
               ptr_in  = ptr_ff - CW'(1);
            end else begin
               state_in = ST_STORE;
            end
         end

         ST_STORE: begin
            wr_en              = 1'b1;
            count_in           = count_ff + CW'(1);
            res_in.position    = 5'(slot_ff);
            res_in.entry_total = 5'(count_ff + CW'(1));
            state_in           = ST_DONE;
         end

         ST_DONE: begin
            if (ctl.take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, count and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      key_ff  <= key_in;
      lo_ff   <= lo_in;
      hip1_ff <= hip1_in;
      mid_ff  <= mid_in;
      slot_ff <= slot_in;
      ptr_ff  <= ptr_in;
      res_ff  <= res_in;
   end

   assign sts.idle = (state_ff == ST_IDLE);
   assign sts.done = (state_ff == ST_DONE);
   assign res      = res_ff;

   // The shift never writes the entry it reads in the same cycle.
   a_shift_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (wr_addr != rd_addr))
      else $error("shift writes the entry it reads");

   // A store adds exactly one key.
   a_store_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STORE) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("store did not advance the count");

   // A finished result reports the count held after the transaction.
   a_total_matches: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (res_ff.entry_total == 5'(count_ff)))
      else $error("result count differs from table count");

   // The count never exceeds the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      sts.idle |-> (count_ff <= CW'(TABLE_DEPTH)))
      else $error("count beyond table depth");

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_key_table_insert_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_mode, req_new_key, req_read_index
// rsp       out        rsp_valid/rsp_ready    rsp_position, rsp_read_key,
//                                             rsp_entry_total, rsp_status
//
// A read goes from acceptance through ST_READ_WAIT to ST_DONE; a rejected
// transaction goes straight to ST_DONE. An insert checks the end entries, may run
// a binary search that reads in ST_SEARCH_RD and compares in ST_SEARCH_CMP; the
// shift moves one entry per cycle through the single write port of the key store.
// Reset clears the state, entry count and rsp_valid; the key store is not cleared.
// A result waits in the output register; the next transaction is accepted
// meanwhile, and the engine holds its own result until the register is free.
module sorted_key_table_insert_top
   import skti_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_BYTES   = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic [63:0] req_new_key,
   input  wire logic [3:0]  req_read_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [4:0]       rsp_position,
   output logic [63:0]      rsp_read_key,
   output logic [4:0]       rsp_entry_total,
   output logic [1:0]       rsp_status
);

   eng_ctl_type ctl;
   eng_sts_type sts;
   cmd_type     cmd;
   res_type     res;

   logic        rsp_valid_ff, rsp_valid_in;
   res_type     rsp_data_ff;

   assign cmd.mode       = req_mode;
   assign cmd.new_key    = req_new_key;
   assign cmd.read_index = req_read_index;

   // Requests enter only when the engine is idle.
   assign req_ready = sts.idle;
   assign ctl.start = req_valid && sts.idle;
   assign ctl.take  = sts.done && (!rsp_valid_ff || rsp_ready);

   skti_engine #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .KEY_BYTES  (KEY_BYTES)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .ctl  (ctl),
      .cmd  (cmd),
      .sts  (sts),
      .res  (res)
   );

   // Output register: loads a finished result when it is empty or draining.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (ctl.take) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_position    = rsp_data_ff.position;
   assign rsp_read_key    = rsp_data_ff.read_key;
   assign rsp_entry_total = rsp_data_ff.entry_total;
   assign rsp_status      = rsp_data_ff.status;

endmodule

`default_nettype wire
